// File: rtl/prfl_pkg.sv
// Shared types and constants for the page run free list allocator.
`default_nettype none

package prfl_pkg;

    localparam int unsigned PageW = 12;
    localparam int unsigned LenW = 13;
    localparam int unsigned Depth = 1 << PageW;
    localparam int unsigned HdrW = PageW + 1 + LenW;
    localparam logic [LenW-1:0] NumPages = 13'd4096;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic [LenW-1:0] run_len;
        logic next_valid;
        logic [PageW-1:0] next_page;
    } hdr_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic [PageW-1:0] addr;
        hdr_t wdata;
    } hdr_req_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

endpackage

`default_nettype wire

// File: rtl/prfl_hdr_ram.sv
// Single-port run header memory with a registered read.
`default_nettype none

module prfl_hdr_ram (
    input  wire logic               aclk,
    input  wire prfl_pkg::hdr_req_t req,
    output prfl_pkg::hdr_t          rdata
);

    prfl_pkg::hdr_t mem [prfl_pkg::Depth];
    prfl_pkg::hdr_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/page_run_free_list_allocator_core.sv
// Top level of the page run free list allocator with its control and output stage.
// An add or failed allocate registers its result in the output stage on acceptance.
// A successful allocate reads the header, then in the read state gives its result and
// writes the rest of the run back, if any. One item is in work at a time; a two-entry
// output stage lets the next item in while a result waits: one add per cycle while
// the output drains. Reset empties the list and output stage, not the header memory.
`default_nettype none

module page_run_free_list_allocator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // page_index [11:0], run_length [24:12]
    input  wire logic [0:0]  s_tuser,  // mode [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // allocated_page [11:0]
    output logic [0:0]       m_tuser   // status [0]
);

    localparam int unsigned PW = prfl_pkg::PageW;
    localparam int unsigned LW = prfl_pkg::LenW;

    prfl_pkg::state_t state_reg, state_next;
    logic [PW-1:0] head_page_reg, head_page_next;
    logic head_valid_reg, head_valid_next;
    logic [LW-1:0] free_count_reg, free_count_next;

    logic out_valid_reg, out_valid_next;
    logic [PW-1:0] out_page_reg, out_page_next;
    logic out_status_reg, out_status_next;
    logic skid_valid_reg, skid_valid_next;
    logic [PW-1:0] skid_page_reg, skid_page_next;
    logic skid_status_reg, skid_status_next;

    prfl_pkg::hdr_req_t req;
    prfl_pkg::hdr_t rdata;

    logic in_fire;
    logic in_mode;
    logic [PW-1:0] in_page;
    logic [LW-1:0] in_len;
    logic res_valid;
    logic [PW-1:0] res_page;
    logic res_status;
    logic [LW:0] count_sum;

    prfl_hdr_ram u_hdr_ram (
        .aclk  (aclk),
        .req   (req),
        .rdata (rdata)
    );

    assign in_mode = s_tuser[0];
    assign in_page = s_tdata[PW-1:0];
    assign in_len = s_tdata[PW+LW-1:PW];
    assign s_tready = (state_reg == prfl_pkg::ST_IDLE) && !skid_valid_reg;
    assign in_fire = s_tvalid && s_tready;
    assign count_sum = {1'b0, free_count_reg} + {1'b0, in_len};

    always_comb begin
        state_next = state_reg;
        head_page_next = head_page_reg;
        head_valid_next = head_valid_reg;
        free_count_next = free_count_reg;
        req = '0;
        res_valid = 1'b0;
        res_page = '0;
        res_status = prfl_pkg::STATUS_OK;
        unique case (state_reg)
            prfl_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (in_mode == prfl_pkg::MODE_ADD) begin
                        res_valid = 1'b1;
                        if (in_len != '0) begin
                            req.wr_en = 1'b1;
                            req.addr = in_page;
                            req.wdata.next_page = head_page_reg;
                            req.wdata.next_valid = head_valid_reg;
                            req.wdata.run_len = in_len;
                            head_page_next = in_page;
                            head_valid_next = 1'b1;
                            if (count_sum > {1'b0, prfl_pkg::NumPages}) begin
                                free_count_next = prfl_pkg::NumPages;
                            end else begin
                                free_count_next = count_sum[LW-1:0];
                            end
                        end
                    end else if (!head_valid_reg) begin
                        res_valid = 1'b1;
                        res_status = prfl_pkg::STATUS_EMPTY;
                    end else begin
                        req.rd_en = 1'b1;
                        req.addr = head_page_reg;
                        state_next = prfl_pkg::ST_READ;
                    end
                end
            end
            prfl_pkg::ST_READ: begin
                res_valid = 1'b1;
                res_page = head_page_reg;
                if (rdata.run_len > LW'(1)) begin
                    req.wr_en = 1'b1;
                    req.addr = head_page_reg + PW'(1);
                    req.wdata.next_page = rdata.next_page;
                    req.wdata.next_valid = rdata.next_valid;
                    req.wdata.run_len = rdata.run_len - LW'(1);
                    head_page_next = head_page_reg + PW'(1);
                end else begin
                    head_page_next = rdata.next_page;
                    head_valid_next = rdata.next_valid;
                end
                if (free_count_reg != '0) begin
                    free_count_next = free_count_reg - LW'(1);
                end
                state_next = prfl_pkg::ST_IDLE;
            end
            default: begin
                state_next = prfl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_page_next = out_page_reg;
        out_status_next = out_status_reg;
        skid_valid_next = skid_valid_reg;
        skid_page_next = skid_page_reg;
        skid_status_next = skid_status_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = skid_valid_reg;
            out_page_next = skid_page_reg;
            out_status_next = skid_status_reg;
            skid_valid_next = 1'b0;
        end
        if (res_valid) begin
            if (!out_valid_next) begin
                out_valid_next = 1'b1;
                out_page_next = res_page;
                out_status_next = res_status;
            end else begin
                skid_valid_next = 1'b1;
                skid_page_next = res_page;
                skid_status_next = res_status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prfl_pkg::ST_IDLE;
            head_page_reg <= '0;
            head_valid_reg <= 1'b0;
            free_count_reg <= '0;
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_page_reg <= head_page_next;
            head_valid_reg <= head_valid_next;
            free_count_reg <= free_count_next;
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_page_reg <= out_page_next;
        out_status_reg <= out_status_next;
        skid_page_reg <= skid_page_next;
        skid_status_reg <= skid_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {{(16 - PW){1'b0}}, out_page_reg};
    assign m_tuser = out_status_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry held while the output register is empty.");

    a_read_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == prfl_pkg::ST_READ) |-> !skid_valid_reg)
        else $error("Allocate completes with no room in the output stage.");

    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.wr_en && req.rd_en))
        else $error("Header memory read and written in the same cycle.");

    a_read_follows_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == prfl_pkg::ST_READ) |-> $past(req.rd_en))
        else $error("Header read state entered without a memory read.");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= prfl_pkg::NumPages)
        else $error("Free page count exceeds the page count.");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for the page run free list allocator: directed and random traffic checked by a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PageW = prfl_pkg::PageW;
    localparam int unsigned LenW = prfl_pkg::LenW;
    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned QuietTail = 100;
    localparam int unsigned DrainCycles = 20;
    localparam int unsigned RandomItems = 800;

    typedef struct packed {
        logic mode;
        logic [PageW-1:0] page;
        logic [LenW-1:0] len;
    } page_req_t;

    typedef struct packed {
        logic [PageW-1:0] page;
        logic status;
    } grant_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0] m_tuser;

    page_req_t request_q[$];
    grant_t grant_q[$];
    page_req_t cur_req = '0;
    int send_gap = 0;
    int stall_len = 0;
    int errors = 0;
    int unsigned cycles = 0;

    logic [PageW-1:0] head_pg = '0;
    logic head_ok = 1'b0;
    logic [LenW-1:0] pages_free = '0;
    prfl_pkg::hdr_t run_hdr [prfl_pkg::Depth];

    page_run_free_list_allocator_core u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic grant_t next_grant(page_req_t r);
        grant_t g;
        prfl_pkg::hdr_t h;
        logic [LenW:0] sum;
        logic [PageW-1:0] moved;
        g.page = '0;
        g.status = prfl_pkg::STATUS_OK;
        if (r.mode == prfl_pkg::MODE_ADD) begin
            if (r.len != '0) begin
                run_hdr[r.page] = '{run_len: r.len, next_valid: head_ok, next_page: head_pg};
                head_pg = r.page;
                head_ok = 1'b1;
                sum = {1'b0, pages_free} + r.len;
                pages_free = (sum > prfl_pkg::NumPages) ? prfl_pkg::NumPages
                                                        : sum[LenW-1:0];
            end
        end else if (!head_ok) begin
            g.status = prfl_pkg::STATUS_EMPTY;
        end else begin
            h = run_hdr[head_pg];
            g.page = head_pg;
            if (h.run_len > 1) begin
                moved = head_pg + 1'b1;
                run_hdr[moved] = '{run_len: h.run_len - 1'b1, next_valid: h.next_valid,
                                   next_page: h.next_page};
                head_pg = moved;
            end else begin
                head_pg = h.next_page;
                head_ok = h.next_valid;
            end
            if (pages_free != '0) pages_free = pages_free - 1'b1;
        end
        return g;
    endfunction

    task automatic add_run(input logic [PageW-1:0] page, input logic [LenW-1:0] len);
        request_q.push_back('{mode: prfl_pkg::MODE_ADD, page: page, len: len});
    endtask

    task automatic take_page();
        request_q.push_back('{mode: prfl_pkg::MODE_ALLOC, page: PageW'($urandom),
                              len: LenW'($urandom)});
    endtask

    always @(posedge aclk) begin
        page_req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) grant_q.push_back(next_grant(cur_req));
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (request_q.size() != 0) begin
                    r = request_q.pop_front();
                    cur_req <= r;
                    s_tdata <= {7'b0, r.len, r.page};
                    s_tuser <= r.mode;
                    s_tvalid <= 1'b1;
                    if (request_q.size() >= QuietTail && $urandom_range(0, 5) == 0) begin
                        send_gap <= $urandom_range(1, 18);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        grant_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_len <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (grant_q.size() == 0) begin
                    $error("unexpected result transaction: allocated_page %0d status %0d",
                           m_tdata[PageW-1:0], m_tuser[0]);
                    errors++;
                end else begin
                    want = grant_q.pop_front();
                    if (m_tdata[PageW-1:0] !== want.page) begin
                        $error("allocated_page: expected %0d, got %0d", want.page,
                               m_tdata[PageW-1:0]);
                        errors++;
                    end
                    if (m_tuser[0] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser[0]);
                        errors++;
                    end
                end
            end
            if (stall_len != 0) begin
                m_tready <= 1'b0;
                stall_len <= stall_len - 1;
            end else begin
                m_tready <= 1'b1;
                if (request_q.size() >= QuietTail && $urandom_range(0, 7) == 0) begin
                    stall_len <= $urandom_range(1, 18);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        int total;
        int n_add;
        int owed;
        int n_take;
        logic [LenW-1:0] len;
        logic [PageW-1:0] page;

        take_page();
        add_run(12'd7, 13'd0);
        take_page();
        add_run(12'd4095, 13'd3);
        take_page();
        take_page();
        take_page();
        take_page();
        add_run(12'd5, 13'd1);
        add_run(12'd9, 13'd2);
        add_run(12'd0, 13'd1);
        take_page();
        take_page();
        take_page();
        take_page();
        take_page();
        add_run(12'hAAA, 13'd2);
        add_run(12'h555, 13'd1);
        take_page();
        take_page();
        take_page();
        take_page();

        total = 0;
        while (total < RandomItems) begin
            n_add = $urandom_range(1, 5);
            owed = 0;
            for (int i = 0; i < n_add; i++) begin
                page = ($urandom_range(0, 7) == 0) ? PageW'($urandom_range(4088, 4095))
                                                   : PageW'($urandom);
                if ($urandom_range(0, 11) == 0) begin
                    len = '0;
                end else if (total > RandomItems - 120 && $urandom_range(0, 2) == 0) begin
                    len = LenW'($urandom_range(5, 8191));
                end else begin
                    len = LenW'($urandom_range(1, 4));
                end
                add_run(page, len);
                if (len != '0) begin
                    total++;
                    owed += (len > 4) ? 4 : int'(len);
                end
                if ($urandom_range(0, 4) == 0) begin
                    take_page();
                    total++;
                end
            end
            n_take = owed + $urandom_range(0, 3) - $urandom_range(0, 2);
            for (int i = 0; i < n_take; i++) begin
                take_page();
                total++;
            end
        end
        add_run(PageW'($urandom), 13'd4096);
        add_run(PageW'($urandom), 13'd8191);
        take_page();
        take_page();
        take_page();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_q.size() != 0 || s_tvalid || grant_q.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
